// ===== rtl/core/srsc_pkg.sv =====
// ----------------------------------------------------------------------------
// srsc_pkg
// Shared types and constants for the shadow return stack checker.
// ----------------------------------------------------------------------------
package srsc_pkg;

  // fixed widths of the payload ports
  localparam int unsigned FIELD_W = 64;

  // defaults of the top level parameters
  localparam int unsigned STACK_DEPTH_DEF = 64;
  localparam int unsigned ADDR_WIDTH_DEF  = 64;

  // configuration port
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned MODE_W     = 2;

  // register index (byte address / 4)
  localparam logic [0:0] REG_MODE = 1'b0;

  // mode bits
  localparam int unsigned MODE_CHECK_BIT = 0;
  localparam int unsigned MODE_SUBST_BIT = 1;

  // per-item status between the stack and the result register
  typedef struct packed {
    logic checked;
    logic attack;
    logic underflow;
    logic overflow;
  } srsc_flags_t;

endpackage

// ===== rtl/core/srsc_cfg.sv =====
// ----------------------------------------------------------------------------
// srsc_cfg
// APB-style register file holding the mode register.
// ----------------------------------------------------------------------------
module srsc_cfg
  import srsc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [MODE_W-1:0]     mode_o
);

  logic [MODE_W-1:0] mode_q;
  logic              sel_mode;
  logic              wr_en;

  // address decode, register index is the word address
  assign sel_mode = (paddr[CFG_ADDR_W-1:2] == REG_MODE);
  assign wr_en    = psel && penable && pwrite && pready;
  assign pready   = 1'b1;

  // mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= '0;
    end else if (wr_en && sel_mode) begin
      mode_q <= pwdata[MODE_W-1:0];
    end
  end

  // read mux
  always_comb begin
    prdata = '0;
    if (sel_mode) begin
      prdata = CFG_DATA_W'(mode_q);
    end
  end

  assign mode_o = mode_q;

endmodule

// ===== rtl/core/srsc_stack.sv =====
// ----------------------------------------------------------------------------
// srsc_stack
// Return-address stack with top pointer, pending-return flag and a
// prefetched pop value, plus the per-item check and substitute logic.
// ----------------------------------------------------------------------------
module srsc_stack
  import srsc_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int unsigned ADDR_WIDTH  = ADDR_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic [MODE_W-1:0]     mode_i,
  input  logic [ADDR_WIDTH-1:0] pc_i,
  input  logic                  call_i,
  input  logic                  ret_i,
  input  logic [ADDR_WIDTH-1:0] raddr_i,
  output logic [ADDR_WIDTH-1:0] eff_pc_o,
  output logic [ADDR_WIDTH-1:0] popped_o,
  output srsc_flags_t           flags_o
);

  localparam int unsigned PTR_W = $clog2(STACK_DEPTH + 1);
  localparam int unsigned IDX_W = $clog2(STACK_DEPTH);

  logic [ADDR_WIDTH-1:0] mem [STACK_DEPTH];

  logic [PTR_W-1:0]      top_q, top_d;
  logic                  pending_q, pending_d;
  logic [ADDR_WIDTH-1:0] rd_q;
  logic [ADDR_WIDTH-1:0] byp_q;
  logic                  byp_valid_q;

  logic                  enabled;
  logic                  pop;
  logic                  under;
  logic                  push;
  logic                  over;
  logic                  push_ok;
  logic [PTR_W-1:0]      top_pop;
  logic [PTR_W-1:0]      rd_ptr;
  logic [ADDR_WIDTH-1:0] popped;

  // pop of the pending return, from the prefetched top entry
  assign enabled = (mode_i != '0);
  assign pop     = enabled && pending_q;
  assign under   = pop && (top_q == '0);
  assign popped  = (pop && !under) ? (byp_valid_q ? byp_q : rd_q) : '0;
  assign top_pop = !pop ? top_q : (under ? '0 : top_q - PTR_W'(1));

  // push of the call's return address, dropped when full
  assign push    = enabled && call_i;
  assign over    = push && (top_pop >= PTR_W'(STACK_DEPTH));
  assign push_ok = push && !over;

  // next pointer and pending flag
  always_comb begin
    top_d     = top_q;
    pending_d = pending_q;
    if (enabled) begin
      top_d     = push_ok ? top_pop + PTR_W'(1) : top_pop;
      pending_d = ret_i;
    end
  end

  assign rd_ptr = top_d - PTR_W'(1);

  // result of this item
  always_comb begin
    eff_pc_o          = pc_i;
    flags_o.checked   = pop;
    flags_o.attack    = 1'b0;
    flags_o.underflow = under;
    flags_o.overflow  = over;
    if (pop) begin
      if (mode_i[MODE_CHECK_BIT]) begin
        flags_o.attack = (pc_i != popped);
      end else begin
        flags_o.attack = (pc_i != '0);
        eff_pc_o       = popped;
      end
    end
  end

  assign popped_o = popped;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q       <= '0;
      pending_q   <= 1'b0;
      byp_valid_q <= 1'b0;
    end else if (step_i && enabled) begin
      top_q     <= top_d;
      pending_q <= pending_d;
      if (ret_i) begin
        byp_valid_q <= push_ok;
      end
    end
  end

  // forwarded push value for a call that also returns
  always_ff @(posedge clk_i) begin
    if (step_i && enabled && ret_i && push_ok) begin
      byp_q <= raddr_i;
    end
  end

  // stack memory write port
  always_ff @(posedge clk_i) begin
    if (step_i && push_ok) begin
      mem[top_pop[IDX_W-1:0]] <= raddr_i;
    end
  end

  // stack memory read port, fetches the entry the next pop will take
  always_ff @(posedge clk_i) begin
    if (step_i && enabled && ret_i) begin
      rd_q <= mem[rd_ptr[IDX_W-1:0]];
    end
  end

endmodule

// ===== rtl/core/shadow_return_stack_checker_unit.sv =====
// ----------------------------------------------------------------------------
// shadow_return_stack_checker_unit
// Shadow call stack that checks or substitutes return targets per code block.
// ----------------------------------------------------------------------------
// One beat per dispatched code block is accepted in every cycle unless the
// output stalls, and each beat gives exactly one result beat through the
// input register, then the result register, so the sustained rate is one
// item per cycle while out_stall_i is low. A return marks the next block for
// a pop, whose entry is read from the stack memory while the returning block
// is processed, so the pop adds no delay. The user must write mode through
// the APB port at byte address 0 only while the block is idle; it does not enforce this.
module shadow_return_stack_checker_unit
  import srsc_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF,
  parameter int unsigned ADDR_WIDTH  = ADDR_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [FIELD_W-1:0]    block_pc_i,
  input  logic                  ends_in_call_i,
  input  logic                  ends_in_return_i,
  input  logic [FIELD_W-1:0]    return_addr_i,
  // output channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [FIELD_W-1:0]    effective_pc_o,
  output logic                  return_checked_o,
  output logic                  attack_flag_o,
  output logic [FIELD_W-1:0]    popped_addr_o,
  output logic                  underflow_o,
  output logic                  overflow_o,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [MODE_W-1:0]     mode;

  logic                  in_valid_q;
  logic [ADDR_WIDTH-1:0] pc_q;
  logic                  call_q;
  logic                  ret_q;
  logic [ADDR_WIDTH-1:0] raddr_q;

  logic                  out_valid_q;
  logic [ADDR_WIDTH-1:0] eff_pc_q;
  logic [ADDR_WIDTH-1:0] popped_q;
  srsc_flags_t           flags_q;

  logic                  advance;
  logic                  in_take;
  logic [ADDR_WIDTH-1:0] eff_pc;
  logic [ADDR_WIDTH-1:0] popped;
  srsc_flags_t           flags;

  // configuration registers
  srsc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .mode_o  (mode)
  );

  // handshake: the input beat moves on when the result register is free
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  // input register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  // input register payload, cut to the address width
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      pc_q    <= block_pc_i[ADDR_WIDTH-1:0];
      call_q  <= ends_in_call_i;
      ret_q   <= ends_in_return_i;
      raddr_q <= return_addr_i[ADDR_WIDTH-1:0];
    end
  end

  // stack and check logic
  srsc_stack #(
    .STACK_DEPTH (STACK_DEPTH),
    .ADDR_WIDTH  (ADDR_WIDTH)
  ) u_stack (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .mode_i   (mode),
    .pc_i     (pc_q),
    .call_i   (call_q),
    .ret_i    (ret_q),
    .raddr_i  (raddr_q),
    .eff_pc_o (eff_pc),
    .popped_o (popped),
    .flags_o  (flags)
  );

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      eff_pc_q <= eff_pc;
      popped_q <= popped;
      flags_q  <= flags;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign effective_pc_o   = FIELD_W'(eff_pc_q);
  assign popped_addr_o    = FIELD_W'(popped_q);
  assign return_checked_o = flags_q.checked;
  assign attack_flag_o    = flags_q.attack;
  assign underflow_o      = flags_q.underflow;
  assign overflow_o       = flags_q.overflow;

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the shadow return stack checker against a cycle-free predictor.
// A queue of code blocks feeds a driver at the falling edge. A monitor at the
// rising edge predicts each accepted beat and compares each result beat with
// the oldest prediction. Mode is set through the APB port between phases.
// ----------------------------------------------------------------------------
module testbench;
  import srsc_pkg::*;

  localparam int          RUN_LIMIT = 600000;
  localparam logic [63:0] ADDR_MASK = {FIELD_W{1'b1}} >> (FIELD_W - ADDR_WIDTH_DEF);

  // mode register values
  localparam logic [MODE_W-1:0] MODE_OFF   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CHECK = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SUBST = 2'd2;
  localparam logic [MODE_W-1:0] MODE_BOTH  = 2'd3;

  // register byte addresses
  localparam logic [CFG_ADDR_W-1:0] MODE_ADDR     = {REG_MODE, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] UNMAPPED_ADDR = 3'd4;

  typedef struct packed {
    logic [FIELD_W-1:0] pc;
    logic               is_call;
    logic               is_ret;
    logic [FIELD_W-1:0] raddr;
  } code_block_t;

  typedef struct packed {
    logic [FIELD_W-1:0] eff_pc;
    logic               checked;
    logic               attack;
    logic [FIELD_W-1:0] popped;
    logic               under;
    logic               over;
  } dispatch_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [FIELD_W-1:0]    block_pc_i;
  logic                  ends_in_call_i;
  logic                  ends_in_return_i;
  logic [FIELD_W-1:0]    return_addr_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [FIELD_W-1:0]    effective_pc_o;
  logic                  return_checked_o;
  logic                  attack_flag_o;
  logic [FIELD_W-1:0]    popped_addr_o;
  logic                  underflow_o;
  logic                  overflow_o;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  shadow_return_stack_checker_unit #(
    .STACK_DEPTH(STACK_DEPTH_DEF),
    .ADDR_WIDTH (ADDR_WIDTH_DEF)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .block_pc_i      (block_pc_i),
    .ends_in_call_i  (ends_in_call_i),
    .ends_in_return_i(ends_in_return_i),
    .return_addr_i   (return_addr_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .effective_pc_o  (effective_pc_o),
    .return_checked_o(return_checked_o),
    .attack_flag_o   (attack_flag_o),
    .popped_addr_o   (popped_addr_o),
    .underflow_o     (underflow_o),
    .overflow_o      (overflow_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always #2 clk_i = ~clk_i;

  // blocks waiting to be driven, dispatches waiting to come out
  code_block_t blocks_to_send[$];
  dispatch_t   predicted_dispatch_q[$];

  // predictor copy of the block state
  logic [MODE_W-1:0]  mode_reg;
  logic [FIELD_W-1:0] shadow_mem[STACK_DEPTH_DEF];
  int                 shadow_top;
  logic               ret_pending;

  // stimulus-side view of the stack, used only to shape well-formed flows
  logic [FIELD_W-1:0] gen_stack[$];
  logic               gen_pending;

  int   error_cnt;
  int   cycle_cnt;
  logic in_taken;
  int   send_gap, send_calm;
  int   stall_left, stall_calm;

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    error_cnt++;
  endtask

  // one dispatch worth of shadow stack behavior
  function automatic dispatch_t predict_dispatch(input code_block_t b);
    dispatch_t          r;
    logic [FIELD_W-1:0] pc;
    logic [FIELD_W-1:0] ra;
    pc        = b.pc & ADDR_MASK;
    ra        = b.raddr & ADDR_MASK;
    r.eff_pc  = pc;
    r.checked = 1'b0;
    r.attack  = 1'b0;
    r.popped  = '0;
    r.under   = 1'b0;
    r.over    = 1'b0;
    if (mode_reg != MODE_OFF) begin
      // pending return takes the top entry
      if (ret_pending) begin
        r.checked = 1'b1;
        if (shadow_top == 0) begin
          r.under = 1'b1;
        end else begin
          shadow_top--;
          r.popped = shadow_mem[shadow_top];
        end
        if (mode_reg[MODE_CHECK_BIT]) begin
          r.attack = (pc != r.popped);
        end else begin
          r.attack = (pc != '0);
          r.eff_pc = r.popped;
        end
      end
      ret_pending = 1'b0;
      // push before the return turns pending
      if (b.is_call) begin
        if (shadow_top >= STACK_DEPTH_DEF) begin
          r.over = 1'b1;
        end else begin
          shadow_mem[shadow_top] = ra;
          shadow_top++;
        end
      end
      if (b.is_ret) ret_pending = 1'b1;
    end
    return r;
  endfunction

  // idle length: mostly short, a few long, with calm stretches of none
  function automatic int idle_len(inout int calm);
    int k;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    k = $urandom_range(0, 99);
    if (k < 2) begin
      calm = $urandom_range(30, 150);
      return 0;
    end
    if (k < 55) return 0;
    if (k < 88) return $urandom_range(1, 3);
    if (k < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [63:0] rand_addr();
    int k;
    k = $urandom_range(0, 15);
    if (k == 0) return '0;
    if (k == 1) return '1;
    if (k == 2) return 64'd1 << $urandom_range(0, 63);
    return {$urandom, $urandom};
  endfunction

  // queue a block and track what it does to the stack
  function automatic void queue_block(input logic [63:0] pc, input logic call,
                                      input logic ret, input logic [63:0] ra);
    code_block_t b;
    b.pc      = pc;
    b.is_call = call;
    b.is_ret  = ret;
    b.raddr   = ra;
    blocks_to_send.push_back(b);
    if (mode_reg != MODE_OFF) begin
      if (gen_pending && gen_stack.size() > 0) void'(gen_stack.pop_back());
      gen_pending = 1'b0;
      if (call && gen_stack.size() < STACK_DEPTH_DEF) gen_stack.push_back(ra);
      if (ret) gen_pending = 1'b1;
    end
  endfunction

  // mostly matched call/return flows, some noise
  function automatic void queue_random_block();
    logic [63:0] pc;
    logic        call;
    logic        ret;
    int          k;
    pc = rand_addr();
    if (gen_pending && $urandom_range(0, 9) < 8) begin
      if (mode_reg[MODE_CHECK_BIT]) pc = (gen_stack.size() > 0) ? gen_stack[$] : '0;
      else if ($urandom_range(0, 3) != 0) pc = '0;
    end
    k    = $urandom_range(0, 99);
    call = 1'b0;
    ret  = 1'b0;
    if (k < 15) begin
      call = 1'($urandom_range(0, 1));
      ret  = 1'($urandom_range(0, 1));
    end else if (k < 50) begin
      call = 1'b1;
    end else if (k < 80) begin
      if (gen_stack.size() == 0 && $urandom_range(0, 9) < 7) call = 1'b1;
      else ret = 1'b1;
    end else if (k < 85) begin
      call = 1'b1;
      ret  = 1'b1;
    end
    queue_block(pc, call, ret, rand_addr());
  endfunction

  task automatic apb_write(input logic [CFG_ADDR_W-1:0] addr,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == MODE_ADDR) mode_reg = data[MODE_W-1:0];
  endtask

  task automatic apb_check_mode();
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= MODE_ADDR;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== {{(CFG_DATA_W-MODE_W){1'b0}}, mode_reg})
      flag_mismatch("mode readback", 64'(prdata), 64'(mode_reg));
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // write mode with junk in the upper bits, then read it back
  task automatic set_mode(input logic [MODE_W-1:0] m);
    apb_write(MODE_ADDR, {(CFG_DATA_W-MODE_W)'($urandom_range(0, 32'h3fff_ffff)), m});
    apb_check_mode();
  endtask

  // sender holds off until every dispatch is back
  task automatic drain_dut();
    while (blocks_to_send.size() != 0 || in_valid_i || predicted_dispatch_q.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // input driver
  always @(negedge clk_i) begin : drive_blk
    code_block_t nb;
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        if (send_gap > 0) begin
          in_valid_i <= 1'b0;
          send_gap   <= send_gap - 1;
        end else if (blocks_to_send.size() > 0) begin
          nb               = blocks_to_send.pop_front();
          block_pc_i       <= nb.pc;
          ends_in_call_i   <= nb.is_call;
          ends_in_return_i <= nb.is_ret;
          return_addr_i    <= nb.raddr;
          in_valid_i       <= 1'b1;
          send_gap         <= idle_len(send_calm);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver stall
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left  <= stall_left - 1;
      end else begin
        out_stall_i <= 1'b0;
        stall_left  <= idle_len(stall_calm);
      end
    end
  end

  // monitor: predict accepted beats, compare result beats
  always @(posedge clk_i) begin : mon_blk
    code_block_t bt;
    dispatch_t   want;
    if (rst_ni) begin
      in_taken = in_valid_i && !in_stall_o;
      if (in_taken) begin
        bt.pc      = block_pc_i;
        bt.is_call = ends_in_call_i;
        bt.is_ret  = ends_in_return_i;
        bt.raddr   = return_addr_i;
        predicted_dispatch_q.push_back(predict_dispatch(bt));
      end
      if (out_valid_o && !out_stall_i) begin
        if (predicted_dispatch_q.size() == 0) begin
          flag_mismatch("dispatch with nothing predicted", effective_pc_o, '0);
        end else begin
          want = predicted_dispatch_q.pop_front();
          if (effective_pc_o !== want.eff_pc)
            flag_mismatch("effective_pc", effective_pc_o, want.eff_pc);
          if (return_checked_o !== want.checked)
            flag_mismatch("return_checked", 64'(return_checked_o), 64'(want.checked));
          if (attack_flag_o !== want.attack)
            flag_mismatch("attack_flag", 64'(attack_flag_o), 64'(want.attack));
          if (popped_addr_o !== want.popped)
            flag_mismatch("popped_addr", popped_addr_o, want.popped);
          if (underflow_o !== want.under)
            flag_mismatch("underflow", 64'(underflow_o), 64'(want.under));
          if (overflow_o !== want.over)
            flag_mismatch("overflow", 64'(overflow_o), 64'(want.over));
        end
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > RUN_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  initial begin : seq_blk
    logic [MODE_W-1:0] phase_modes[6];
    int                burst_at;
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    block_pc_i       = '0;
    ends_in_call_i   = 1'b0;
    ends_in_return_i = 1'b0;
    return_addr_i    = '0;
    out_stall_i      = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    mode_reg         = MODE_OFF;
    shadow_top       = 0;
    ret_pending      = 1'b0;
    gen_pending      = 1'b0;
    error_cnt        = 0;
    cycle_cnt        = 0;
    in_taken         = 1'b0;
    send_gap         = 0;
    send_calm        = 0;
    stall_left       = 0;
    stall_calm       = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    apb_check_mode();

    // disabled after reset: nothing pops or pushes
    queue_block('1, 1'b1, 1'b1, '1);
    queue_block('0, 1'b0, 1'b0, '0);
    drain_dut();

    // check mode: match, mismatch, underflow, call and return together
    set_mode(MODE_CHECK);
    queue_block(64'h0000_0000_0040_0000, 1'b1, 1'b0, 64'h0000_0000_0040_1000);
    queue_block(64'h0000_0000_0040_2000, 1'b1, 1'b0, '1);
    queue_block(64'h0000_0000_0040_3000, 1'b0, 1'b1, '0);
    queue_block('1, 1'b0, 1'b1, 64'h5555_5555_5555_5555);
    queue_block(64'h0000_0000_0000_1234, 1'b0, 1'b1, '0);
    queue_block('0, 1'b0, 1'b1, '0);
    queue_block(64'h0000_0000_0000_0005, 1'b1, 1'b1, 64'haaaa_aaaa_aaaa_aaaa);
    queue_block(64'haaaa_aaaa_aaaa_aaaa, 1'b0, 1'b0, '0);
    drain_dut();

    // substitute mode: popped address dispatches, empty pop goes to zero
    set_mode(MODE_SUBST);
    queue_block(64'h0000_7fff_0000_0000, 1'b1, 1'b0, 64'h0000_7fff_0000_0100);
    queue_block(64'h0000_7fff_0000_0200, 1'b0, 1'b1, '0);
    queue_block('0, 1'b0, 1'b1, '0);
    queue_block(64'h8000_0000_0000_0000, 1'b0, 1'b1, '0);
    drain_dut();

    // disabled with a return pending: the flag must survive
    set_mode(MODE_OFF);
    queue_block(64'h0000_0000_dead_0000, 1'b1, 1'b0, 64'h0000_0000_dead_0004);
    drain_dut();

    // both bits set: check mode wins
    set_mode(MODE_BOTH);
    queue_block(64'h0000_0000_0000_0040, 1'b1, 1'b0, 64'h0000_0000_0000_0080);
    queue_block(64'h0000_0000_0000_0060, 1'b0, 1'b1, '0);
    queue_block(64'h0000_0000_0000_0099, 1'b0, 1'b0, '0);
    drain_dut();

    // write to an unmapped address is ignored
    apb_write(UNMAPPED_ADDR, '1);
    apb_check_mode();

    // random phases, one overflow burst in each enabled phase
    phase_modes = '{MODE_CHECK, MODE_SUBST, MODE_BOTH, MODE_OFF, MODE_CHECK, MODE_SUBST};
    foreach (phase_modes[p]) begin
      set_mode(phase_modes[p]);
      burst_at = (phase_modes[p] != MODE_OFF) ? $urandom_range(0, 139) : -1;
      for (int i = 0; i < 140; i++) begin
        if (i == burst_at) begin
          repeat (STACK_DEPTH_DEF + 2) queue_block(rand_addr(), 1'b1, 1'b0, rand_addr());
        end
        queue_random_block();
      end
      drain_dut();
    end

    repeat (8) @(posedge clk_i);
    if (predicted_dispatch_q.size() != 0)
      flag_mismatch("dispatches never came", 64'(predicted_dispatch_q.size()), 64'(0));
    if (error_cnt == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/srsc_pkg.sv
rtl/core/srsc_cfg.sv
rtl/core/srsc_stack.sv
rtl/core/shadow_return_stack_checker_unit.sv
dv/testbench.sv
